@@ hdl/fqs_pkg.sv @@
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared codes, result types and saturating helpers for the FASTQ read
// quality statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package fqs_pkg;

  // request modes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_SUMMARY = 2'd1;
  localparam logic [1:0] MODE_BIN     = 2'd2;

  // report kinds
  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_BIN     = 1'b1;

  // configuration register indexes
  localparam logic CFG_Q_LOW  = 1'b0;
  localparam logic CFG_Q_HIGH = 1'b1;

  // threshold reset values (Q20 and Q30 with phred+33 offset)
  localparam logic [6:0] Q_LOW_RESET  = 7'd53;
  localparam logic [6:0] Q_HIGH_RESET = 7'd63;

  localparam logic [7:0] NEWLINE = 8'd10;

  // running totals as seen on the result port
  typedef struct packed {
    logic [31:0] reads_total;
    logic [47:0] base_count;
    logic [8:0]  min_len;
    logic [8:0]  max_len;
    logic [47:0] quality_bases;
    logic [47:0] q_low_bases;
    logic [47:0] q_high_bases;
    logic        length_clamped;
  } stats_t;

  // one result item
  typedef struct packed {
    logic        report_kind;
    stats_t      stats;
    logic [31:0] bin_count;
  } res_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    return (a == '1) ? a : a + 32'd1;
  endfunction

  function automatic logic [47:0] sat_inc48(input logic [47:0] a);
    return (a == '1) ? a : a + 48'd1;
  endfunction

endpackage

`default_nettype wire

@@ hdl/fastq_read_quality_stats.sv @@
// ----------------------------------------------------------------------------
// fastq_read_quality_stats
// FASTQ read length and Q20/Q30 statistics from an uncompressed byte stream.
// ----------------------------------------------------------------------------
// Takes one request per clock unless in_stall is high: a FASTQ byte (mode 0),
// a summary report (mode 1) or a summary plus one read length histogram bin
// (mode 2). Byte requests give no result; a report passes the report stage
// and the result queue on its way out, and reports keep one per cycle while
// the result side takes them. The histogram is a MAX_LEN-entry RAM updated
// by read-modify-write; after reset a clearing pass writes one bin per
// cycle and the input stalls until every bin is cleared. Thresholds are to
// be written through the cfg port while no request is in flight (unchecked).
// ----------------------------------------------------------------------------
`default_nettype none

module fastq_read_quality_stats import fqs_pkg::*; #(
  parameter int MAX_LEN = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [8:0]  in_bin_index,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_report_kind,
  output logic [31:0]      out_reads_total,
  output logic [47:0]      out_base_count,
  output logic [8:0]       out_min_len,
  output logic [8:0]       out_max_len,
  output logic [47:0]      out_quality_bases,
  output logic [47:0]      out_q_low_bases,
  output logic [47:0]      out_q_high_bases,
  output logic [31:0]      out_bin_count,
  output logic             out_length_clamped,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_LEN);

  logic [6:0]    q_low_r;
  logic [6:0]    q_high_r;

  logic          accept;
  logic          byte_go;
  logic          report_go;
  logic          bin_in_range;
  logic          rd_valid;

  stats_t        stats;
  logic          upd_valid;
  logic [AW-1:0] upd_addr;
  logic          hist_busy;
  logic [31:0]   bin_data;

  logic          s1_v_r;
  logic          s1_kind_r;
  stats_t        s1_stats_r;

  res_t          push_data;
  res_t          head;
  logic [1:0]    q_level;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_low_r  <= Q_LOW_RESET;
      q_high_r <= Q_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_Q_LOW:  q_low_r  <= cfg_wdata;
        CFG_Q_HIGH: q_high_r <= cfg_wdata;
        default:    q_low_r  <= q_low_r;
      endcase
    end
  end

  // request decode; stall while clearing or when no room for a report
  assign in_stall     = hist_busy || (({1'b0, s1_v_r} + q_level) >= 2'd2);
  assign accept       = in_valid && !in_stall;
  assign byte_go      = accept && (in_mode == MODE_BYTE);
  assign report_go    = accept && ((in_mode == MODE_SUMMARY) || (in_mode == MODE_BIN));
  assign bin_in_range = (32'(in_bin_index) < MAX_LEN);
  assign rd_valid     = accept && (in_mode == MODE_BIN) && bin_in_range;

  fqs_scan #(
    .MAX_LEN (MAX_LEN)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_go   (byte_go),
    .data_byte (in_data_byte),
    .q_low     (q_low_r),
    .q_high    (q_high_r),
    .stats     (stats),
    .upd_valid (upd_valid),
    .upd_addr  (upd_addr)
  );

  fqs_hist #(
    .MAX_LEN (MAX_LEN)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_valid (upd_valid),
    .upd_addr  (upd_addr),
    .rd_valid  (rd_valid),
    .rd_addr   (AW'(in_bin_index)),
    .busy      (hist_busy),
    .bin_data  (bin_data)
  );

  // report stage: totals snapshot while the bin read is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= report_go;
    end
  end

  always_ff @(posedge clk) begin
    if (report_go) begin
      s1_kind_r  <= (in_mode == MODE_BIN) ? KIND_BIN : KIND_SUMMARY;
      s1_stats_r <= stats;
    end
  end

  always_comb begin
    push_data.report_kind = s1_kind_r;
    push_data.stats       = s1_stats_r;
    push_data.bin_count   = bin_data;
  end

  fqs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (head),
    .level     (q_level)
  );

  // result fields
  assign out_report_kind    = head.report_kind;
  assign out_reads_total    = head.stats.reads_total;
  assign out_base_count     = head.stats.base_count;
  assign out_min_len        = head.stats.min_len;
  assign out_max_len        = head.stats.max_len;
  assign out_quality_bases  = head.stats.quality_bases;
  assign out_q_low_bases    = head.stats.q_low_bases;
  assign out_q_high_bases   = head.stats.q_high_bases;
  assign out_bin_count      = head.bin_count;
  assign out_length_clamped = head.stats.length_clamped;

  // an accepted report reaches the report stage on the next cycle
  a_report_staged : assert property (@(posedge clk) disable iff (!rst_n)
    report_go |=> s1_v_r)
    else $error("accepted report did not reach the report stage");

endmodule

`default_nettype wire

@@ hdl/fqs_ram.sv @@
// ----------------------------------------------------------------------------
// fqs_ram
// Generic simple dual port RAM: one write port, one read port, registered
// read data. A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/fqs_scan.sv @@
// ----------------------------------------------------------------------------
// fqs_scan
// Line parser and running totals: tracks the record line phase and the
// position on the line, ends sequence lines into a length, and counts
// quality characters against the two thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_scan import fqs_pkg::*; #(
  parameter int MAX_LEN = 512,
  localparam int LW = $clog2(MAX_LEN)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_go,
  input  wire logic [7:0]    data_byte,
  input  wire logic [6:0]    q_low,
  input  wire logic [6:0]    q_high,
  output stats_t             stats,
  output logic               upd_valid,
  output logic [LW-1:0]      upd_addr
);

  localparam int PW = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {PH_HEADER, PH_SEQ, PH_SEP, PH_QUAL} phase_t;

  phase_t         phase_r, phase_nxt;
  logic [PW-1:0]  pos_r;
  logic [LW-1:0]  cur_len_r;
  logic [31:0]    reads_r;
  logic [47:0]    bases_r, bases_nxt;
  logic [LW-1:0]  shortest_r;
  logic [LW-1:0]  longest_r;
  logic [47:0]    qual_tot_r;
  logic [47:0]    qual_low_r;
  logic [47:0]    qual_high_r;
  logic           clamp_r;

  logic           is_nl;
  logic           too_long;
  logic [LW-1:0]  seq_len;
  logic           seq_end;
  logic           qual_hit;
  logic [48:0]    bases_sum;

  // byte classification
  assign is_nl    = (data_byte == NEWLINE);
  assign too_long = (pos_r > PW'(MAX_LEN - 1));
  assign seq_len  = too_long ? LW'(MAX_LEN - 1) : LW'(pos_r);
  assign seq_end  = byte_go && is_nl && (phase_r == PH_SEQ);
  assign qual_hit = byte_go && !is_nl && (phase_r == PH_QUAL) && (pos_r < PW'(cur_len_r));

  // saturating base count
  assign bases_sum = {1'b0, bases_r} + 49'(seq_len);
  assign bases_nxt = bases_sum[48] ? '1 : bases_sum[47:0];

  // next line phase, wraps after the quality line
  always_comb begin
    case (phase_r)
      PH_HEADER: phase_nxt = PH_SEQ;
      PH_SEQ:    phase_nxt = PH_SEP;
      PH_SEP:    phase_nxt = PH_QUAL;
      PH_QUAL:   phase_nxt = PH_HEADER;
      default:   phase_nxt = PH_HEADER;
    endcase
  end

  // parser state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      cur_len_r   <= '0;
      reads_r     <= '0;
      bases_r     <= '0;
      shortest_r  <= '1;
      longest_r   <= '0;
      qual_tot_r  <= '0;
      qual_low_r  <= '0;
      qual_high_r <= '0;
      clamp_r     <= 1'b0;
    end else begin
      if (byte_go) begin
        if (is_nl) begin
          phase_r <= phase_nxt;
          pos_r   <= '0;
        end else if (pos_r < PW'(MAX_LEN)) begin
          pos_r <= pos_r + PW'(1);
        end
      end
      if (seq_end) begin
        cur_len_r <= seq_len;
        reads_r   <= sat_inc32(reads_r);
        bases_r   <= bases_nxt;
        if (seq_len < shortest_r) begin
          shortest_r <= seq_len;
        end
        if (seq_len > longest_r) begin
          longest_r <= seq_len;
        end
        if (too_long) begin
          clamp_r <= 1'b1;
        end
      end
      if (qual_hit) begin
        qual_tot_r <= sat_inc48(qual_tot_r);
        if (data_byte >= {1'b0, q_low}) begin
          qual_low_r <= sat_inc48(qual_low_r);
        end
        if (data_byte >= {1'b0, q_high}) begin
          qual_high_r <= sat_inc48(qual_high_r);
        end
      end
    end
  end

  // histogram increment for each finished sequence line
  assign upd_valid = seq_end;
  assign upd_addr  = seq_len;

  // totals as reported
  always_comb begin
    stats.reads_total    = reads_r;
    stats.base_count     = bases_r;
    stats.min_len        = (reads_r == '0) ? 9'd0 : 9'(shortest_r);
    stats.max_len        = 9'(longest_r);
    stats.quality_bases  = qual_tot_r;
    stats.q_low_bases    = qual_low_r;
    stats.q_high_bases   = qual_high_r;
    stats.length_clamped = clamp_r;
  end

endmodule

`default_nettype wire

@@ hdl/fqs_hist.sv @@
// ----------------------------------------------------------------------------
// fqs_hist
// Read length histogram in one RAM: clearing pass after reset, saturating
// read-modify-write increments, and bin reads with forwarding of a write
// to the same bin in the cycle the read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_hist import fqs_pkg::*; #(
  parameter int MAX_LEN = 512,
  localparam int AW = $clog2(MAX_LEN)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          upd_valid,
  input  wire logic [AW-1:0] upd_addr,
  input  wire logic          rd_valid,
  input  wire logic [AW-1:0] rd_addr,
  output logic               busy,
  output logic [31:0]        bin_data
);

  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;
  logic          upd_v_r;
  logic [AW-1:0] upd_addr_r;
  logic          ok_r;
  logic          fwd_v_r;
  logic [31:0]   fwd_data_r;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  // write port: clearing sweep or the increment write-back
  assign we    = clr_active_r || upd_v_r;
  assign waddr = clr_active_r ? clr_addr_r : upd_addr_r;
  assign wdata = clr_active_r ? 32'd0 : sat_inc32(rdata);

  // read port: an increment and a bin read never come in the same cycle
  assign raddr = upd_valid ? upd_addr : rd_addr;

  fqs_ram #(
    .WIDTH (32),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // clearing sweep, one bin per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == AW'(MAX_LEN - 1)) begin
        clr_active_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // increment and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_v_r <= 1'b0;
      ok_r    <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      upd_v_r <= upd_valid;
      ok_r    <= rd_valid;
      fwd_v_r <= rd_valid && we && (waddr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    upd_addr_r <= upd_addr;
    fwd_data_r <= wdata;
  end

  assign busy     = clr_active_r;
  assign bin_data = !ok_r ? 32'd0 : (fwd_v_r ? fwd_data_r : rdata);

  // histogram increments never overlap: the next one is a record away
  a_no_rmw_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    upd_v_r |-> !upd_valid)
    else $error("histogram increment issued during a pending write-back");

  // no access while the sweep owns the RAM
  a_idle_while_clear : assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> (!upd_valid && !rd_valid))
    else $error("histogram access during clearing pass");

endmodule

`default_nettype wire

@@ hdl/fqs_outq.sv @@
// ----------------------------------------------------------------------------
// fqs_outq
// Two-entry result queue: an output register and a skid register, so the
// input side keeps going while a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fqs_outq import fqs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire res_t  push_data,
  input  wire logic  out_stall,
  output logic       out_valid,
  output res_t       out_data,
  output logic [1:0] level
);

  logic head_v_r, head_v_nxt;
  res_t head_r, head_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop = head_v_r && !out_stall;

  // pop first, then place the new result in the first free slot
  always_comb begin
    head_v_nxt = head_v_r;
    head_nxt   = head_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        head_v_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!head_v_nxt) begin
        head_v_nxt = 1'b1;
        head_nxt   = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = head_v_r;
  assign out_data  = head_r;
  assign level     = {1'b0, head_v_r} + {1'b0, skid_v_r} - {1'b0, pop};

  // never push into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    !(push && skid_v_r && !pop))
    else $error("result queue overflow");

  // skid entry only behind a valid head
  a_skid_behind_head : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> head_v_r)
    else $error("skid entry without head entry");

endmodule

`default_nettype wire

@@ test/fqs_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fqs_checker
// Watches the request, result and register ports of the FASTQ statistics
// block. It keeps its own line tracking, counters and length histogram, works
// out each report when its request is taken, and compares reports in order.
// ----------------------------------------------------------------------------

module fqs_checker import fqs_pkg::*; #(
  parameter int MAX_LEN = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  input  logic [8:0]  in_bin_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_report_kind,
  input  logic [31:0] out_reads_total,
  input  logic [47:0] out_base_count,
  input  logic [8:0]  out_min_len,
  input  logic [8:0]  out_max_len,
  input  logic [47:0] out_quality_bases,
  input  logic [47:0] out_q_low_bases,
  input  logic [47:0] out_q_high_bases,
  input  logic [31:0] out_bin_count,
  input  logic        out_length_clamped,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata,
  output int          errors,
  output int          reports_due
);

  typedef enum logic [1:0] {
    LINE_HEADER,
    LINE_SEQUENCE,
    LINE_SEPARATOR,
    LINE_QUALITY
  } line_kind_t;

  logic [6:0]  q_low_min;
  logic [6:0]  q_high_min;
  line_kind_t  line_kind;
  logic [9:0]  line_pos;
  logic [8:0]  read_len;
  logic [31:0] len_hist [MAX_LEN];
  logic [31:0] n_reads;
  logic [47:0] n_bases;
  logic [9:0]  shortest;
  logic [8:0]  longest;
  logic [47:0] n_qual;
  logic [47:0] n_qual_low;
  logic [47:0] n_qual_high;
  logic        clamped;
  res_t        pending_reports[$];

  // end of a sequence line: record the (clamped) read length
  task automatic close_sequence_line();
    logic [8:0]  len;
    logic [48:0] total;
    if (line_pos > MAX_LEN - 1) begin
      len = 9'(MAX_LEN - 1);
      clamped = 1'b1;
    end else begin
      len = line_pos[8:0];
    end
    read_len = len;
    if (~&n_reads) n_reads++;
    total = n_bases + len;
    n_bases = total[48] ? '1 : total[47:0];
    if (~&len_hist[len]) len_hist[len]++;
    if (len < shortest) shortest = {1'b0, len};
    if (len > longest) longest = len;
  endtask

  // one streamed FASTQ byte
  task automatic take_fastq_byte(input logic [7:0] b);
    if (b == NEWLINE) begin
      if (line_kind == LINE_SEQUENCE) close_sequence_line();
      line_kind = line_kind_t'(line_kind + 2'd1);
      line_pos = '0;
    end else begin
      // quality bytes past the read length are dropped
      if (line_kind == LINE_QUALITY && line_pos < read_len) begin
        if (~&n_qual) n_qual++;
        if (b >= q_low_min && ~&n_qual_low) n_qual_low++;
        if (b >= q_high_min && ~&n_qual_high) n_qual_high++;
      end
      if (line_pos < MAX_LEN) line_pos++;
    end
  endtask

  function automatic res_t build_report(input logic [1:0] mode, input logic [8:0] bin);
    res_t r;
    r.report_kind = (mode == MODE_BIN) ? KIND_BIN : KIND_SUMMARY;
    r.stats.reads_total = n_reads;
    r.stats.base_count = n_bases;
    r.stats.min_len = (n_reads == 0) ? '0 : shortest[8:0];
    r.stats.max_len = longest;
    r.stats.quality_bases = n_qual;
    r.stats.q_low_bases = n_qual_low;
    r.stats.q_high_bases = n_qual_high;
    r.stats.length_clamped = clamped;
    r.bin_count = (mode == MODE_BIN && bin < MAX_LEN) ? len_hist[bin] : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      q_low_min = Q_LOW_RESET;
      q_high_min = Q_HIGH_RESET;
      line_kind = LINE_HEADER;
      line_pos = '0;
      read_len = '0;
      for (int i = 0; i < MAX_LEN; i++) len_hist[i] = '0;
      n_reads = '0;
      n_bases = '0;
      shortest = '1;
      longest = '0;
      n_qual = '0;
      n_qual_low = '0;
      n_qual_high = '0;
      clamped = 1'b0;
      pending_reports.delete();
      errors = 0;
    end else begin
      // threshold writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_Q_LOW:  q_low_min = cfg_wdata;
          CFG_Q_HIGH: q_high_min = cfg_wdata;
          default: ;
        endcase
      end
      // compare a taken report with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          $error("report arrived with none pending");
          errors++;
        end else begin
          want = pending_reports.pop_front();
          check_field("report_kind", want.report_kind, out_report_kind);
          check_field("reads_total", want.stats.reads_total, out_reads_total);
          check_field("base_count", want.stats.base_count, out_base_count);
          check_field("min_len", want.stats.min_len, out_min_len);
          check_field("max_len", want.stats.max_len, out_max_len);
          check_field("quality_bases", want.stats.quality_bases, out_quality_bases);
          check_field("q_low_bases", want.stats.q_low_bases, out_q_low_bases);
          check_field("q_high_bases", want.stats.q_high_bases, out_q_high_bases);
          check_field("bin_count", want.bin_count, out_bin_count);
          check_field("length_clamped", want.stats.length_clamped, out_length_clamped);
        end
      end
      // accepted request
      if (in_valid && !in_stall) begin
        case (in_mode)
          MODE_BYTE: take_fastq_byte(in_data_byte);
          MODE_SUMMARY, MODE_BIN:
            pending_reports.push_back(build_report(in_mode, in_bin_index));
          default: ;
        endcase
      end
    end
    reports_due = pending_reports.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the FASTQ read quality statistics block. Streams directed and
// random FASTQ records, noise and report requests under several threshold
// settings, with random idle and stall bursts; the checker does the compare.
// ----------------------------------------------------------------------------

module tb;
  import fqs_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         SETTLE      = 4;
  localparam logic [7:0] CR          = 8'd13;
  localparam logic [7:0] PLUS        = "+";
  localparam logic [7:0] AT          = "@";
  localparam logic [39:0] ACGTN      = "ACGTN";

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [7:0]  in_data_byte;
  logic [8:0]  in_bin_index;
  logic        out_valid;
  logic        out_stall;
  logic        out_report_kind;
  logic [31:0] out_reads_total;
  logic [47:0] out_base_count;
  logic [8:0]  out_min_len;
  logic [8:0]  out_max_len;
  logic [47:0] out_quality_bases;
  logic [47:0] out_q_low_bases;
  logic [47:0] out_q_high_bases;
  logic [31:0] out_bin_count;
  logic        out_length_clamped;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_wdata;

  int          errors;
  int          reports_due;
  bit          idle_on;
  logic [1:0]  nl_phase;
  int          items_sent;
  int          reports_sent;
  int          stall_left = 0;
  int          cycle_count = 0;

  fastq_read_quality_stats uut (.*);

  fqs_checker stats_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // random result side stall bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall = 1'b0;
    end
  end

  // one request, held until taken; valid stays high afterwards
  task automatic send_req(input logic [1:0] mode, input logic [7:0] data,
                          input logic [8:0] bin);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode = mode;
    in_data_byte = data;
    in_bin_index = bin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (mode == MODE_BYTE && data == NEWLINE) nl_phase++;
    if (mode == MODE_SUMMARY || mode == MODE_BIN) reports_sent++;
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(MODE_BYTE, b, 9'($urandom_range(0, 511)));
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == NEWLINE) ? CR : b;
  endfunction

  // one four-line record, lined up on a header first
  task automatic send_record(input int seq_len, input int qual_len);
    while (nl_phase != 2'd0) send_byte(NEWLINE);
    send_byte(AT);
    repeat ($urandom_range(0, 4)) send_byte(text_byte());
    send_byte(NEWLINE);
    repeat (seq_len)
      send_byte(($urandom_range(0, 9) == 0) ? text_byte()
                                            : ACGTN[8 * $urandom_range(0, 4) +: 8]);
    send_byte(NEWLINE);
    send_byte(PLUS);
    send_byte(NEWLINE);
    repeat (qual_len)
      send_byte(($urandom_range(0, 3) == 0) ? text_byte() : 8'($urandom_range(33, 74)));
    send_byte(NEWLINE);
  endtask

  // wait for every report, then let in-flight bytes settle
  task automatic drain_reports();
    in_valid = 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly well-formed records with reports mixed in, some noise
  task automatic run_random(input int n_items, input int n_reports);
    int first_items;
    int first_reports;
    int pick;
    int len;
    first_items = items_sent;
    first_reports = reports_sent;
    while (items_sent - first_items < n_items || reports_sent - first_reports < n_reports) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
        send_record(len, ($urandom_range(0, 2) == 0) ? $urandom_range(0, len + 4) : len);
      end else if (pick < 11) begin
        send_req(MODE_SUMMARY, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      end else if (pick < 16) begin
        send_req(MODE_BIN, 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 12))
                                             : 9'($urandom_range(0, 511)));
      end else if (pick < 18) begin
        send_req(MODE_UNUSED, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(0, 2) == 0) ? NEWLINE : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_BYTE;
    in_data_byte = '0;
    in_bin_index = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_Q_LOW;
    cfg_wdata = '0;
    idle_on = 1'b1;
    nl_phase = '0;
    items_sent = 0;
    reports_sent = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // empty block: no reads, min length reads 0
    send_req(MODE_SUMMARY, 8'h00, 9'h000);
    send_req(MODE_BIN, 8'hFF, 9'h1FF);
    send_req(MODE_BIN, 8'h00, 9'h000);
    send_req(MODE_UNUSED, 8'hFF, 9'h1FF);
    // header with extreme bytes, sequence ending in carriage return
    send_byte(AT);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(NEWLINE);
    send_byte("A");
    send_byte("C");
    send_byte(CR);
    send_byte(NEWLINE);
    send_byte(PLUS);
    send_byte(NEWLINE);
    // high byte, at and below threshold, then extra quality bytes
    send_byte(8'hFF);
    send_byte(8'd53);
    send_byte(8'd52);
    send_byte(8'd63);
    send_byte(8'd127);
    send_byte(NEWLINE);
    send_req(MODE_BIN, 8'h00, 9'd3);
    // unfinished sequence line, reported before and after its newline
    send_byte(AT);
    send_byte(NEWLINE);
    send_byte("G");
    send_byte("T");
    send_req(MODE_SUMMARY, 8'h00, 9'h000);
    send_byte(NEWLINE);
    send_req(MODE_SUMMARY, 8'hFF, 9'h1FF);

    run_random(20, 4);
    drain_reports();

    // lowest and highest thresholds, plus a long read past the clamp
    write_reg(CFG_Q_LOW, 7'd0);
    write_reg(CFG_Q_HIGH, 7'd127);
    send_record(514, 12);
    send_req(MODE_SUMMARY, 8'h00, 9'h000);
    send_req(MODE_BIN, 8'h00, 9'd511);
    run_random(20, 4);
    drain_reports();

    write_reg(CFG_Q_LOW, 7'd127);
    write_reg(CFG_Q_HIGH, 7'd0);
    run_random(20, 4);
    drain_reports();

    // random thresholds, no idling to the end
    write_reg(CFG_Q_LOW, 7'($urandom_range(0, 127)));
    write_reg(CFG_Q_HIGH, 7'($urandom_range(0, 127)));
    idle_on = 1'b0;
    run_random(20, 4);
    drain_reports();
    repeat (SETTLE) @(negedge clk);

    if (errors == 0 && reports_due == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
